FILE: src/ema_with_sma_seed_unit_macros.svh
// Assertion macros shared by the moving average unit files.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef EMA_WITH_SMA_SEED_UNIT_MACROS_SVH
`define EMA_WITH_SMA_SEED_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define EWSS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

`define EWSS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`define EWSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check violated");

`else

`define EWSS_ASSERT_ALWAYS(lbl, clk, rst, expr)

`define EWSS_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define EWSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: src/ewss_pkg.sv
// Shared types, widths and register codes for the moving average unit.
// No dependencies.
package ewss_pkg;

   localparam int PRICE_W  = 32;
   localparam int TIME_W   = 40;
   localparam int ALPHA_W  = 17;
   localparam int PROD_W   = PRICE_W + ALPHA_W;
   localparam int PERIOD_W = 11;
   localparam int MUL_CNT_W = $clog2(ALPHA_W + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

   // default alpha = 131072 / (N+1)
   localparam int                      ALPHA_DIVD_W = 18;
   localparam logic [ALPHA_DIVD_W-1:0] ALPHA_DIVD   = 18'd131072;

   localparam logic [PRICE_W-1:0] PRICE_MAX = 32'hFFFF_FFFF;

   localparam logic [1:0] REG_PERIOD        = 2'd0;
   localparam logic [1:0] REG_DEFAULT_ALPHA = 2'd1;
   localparam logic [1:0] REG_SMOOTHING     = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_status_type;

   function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_DIVD_W-1:0] a);
      if (a > ALPHA_DIVD_W'(ALPHA_ONE)) begin
         return ALPHA_ONE;
      end
      return a[ALPHA_W-1:0];
   endfunction

endpackage

FILE: src/ewss_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ewss_pkg and the assertion macro header.
`include "ema_with_sma_seed_unit_macros.svh"

module ewss_divider import ewss_pkg::*; #(
   parameter int DIVD_W = 42,
   parameter int DIVS_W = 11,
   parameter int ITER_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   input  logic [ITER_W-1:0] iterations,
   output serial_status_type status,
   output logic [DIVD_W-1:0] quotient
);

   logic [DIVD_W-1:0] shreg_ff, shreg_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] divisor_ff, divisor_in;
   logic [ITER_W-1:0] left_ff, left_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIVS_W:0]   trial;
   logic              qbit;

   // dividend bits leave at the top, quotient bits enter at the bottom
   assign trial = {rem_ff, shreg_ff[DIVD_W-1]};
   assign qbit  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      shreg_in   = shreg_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      left_in    = left_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         shreg_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         left_in    = iterations;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         shreg_in = {shreg_ff[DIVD_W-2:0], qbit};
         rem_in   = qbit ? DIVS_W'(trial - {1'b0, divisor_ff}) : trial[DIVS_W-1:0];
         left_in  = left_ff - ITER_W'(1);
         if (left_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
      shreg_ff   <= shreg_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shreg_ff;

   `EWSS_ASSERT_IMPL(a_div_no_restart, clock, reset, start, !busy_ff)
   `EWSS_ASSERT_IMPL(a_div_rem_below, clock, reset, busy_ff, rem_ff < divisor_ff)
   `EWSS_ASSERT_NEXT(a_div_done_once, clock, reset, done_ff, !done_ff)

endmodule

FILE: src/ewss_multiplier.sv
// Bit-serial shift-add multiplier: alpha times a price difference, MSB first.
// Depends on ewss_pkg and the assertion macro header.
`include "ema_with_sma_seed_unit_macros.svh"

module ewss_multiplier import ewss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ALPHA_W-1:0] alpha,
   input  logic [PRICE_W-1:0] operand,
   output serial_status_type  status,
   output logic [PROD_W-1:0]  product
);

   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [PRICE_W-1:0]   operand_ff, operand_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] left_ff, left_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      alpha_in   = alpha_ff;
      operand_in = operand_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         alpha_in   = alpha;
         operand_in = operand;
         acc_in     = '0;
         left_in    = MUL_CNT_W'(ALPHA_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         acc_in   = {acc_ff[PROD_W-2:0], 1'b0}
                  + (alpha_ff[ALPHA_W-1] ? PROD_W'(operand_ff) : '0);
         alpha_in = {alpha_ff[ALPHA_W-2:0], 1'b0};
         left_in  = left_ff - MUL_CNT_W'(1);
         if (left_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
      alpha_ff   <= alpha_in;
      operand_ff <= operand_in;
      acc_ff     <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

   `EWSS_ASSERT_IMPL(a_mul_no_restart, clock, reset, start, !busy_ff)
   `EWSS_ASSERT_IMPL(a_mul_drained, clock, reset, done_ff, alpha_ff == '0)
   `EWSS_ASSERT_IMPL(a_mul_status_excl, clock, reset, done_ff, !busy_ff)

endmodule

FILE: src/ema_with_sma_seed_unit.sv
// Exponential moving average with a simple-average seed. Each transaction
// carries one Q16.16 price and a timestamp. The first N-1 samples of a series
// are summed and give no result; the Nth starts a bit-serial divide of the sum
// by the count, one step for each of the 42 sum bits at the default MAX_PERIOD,
// and the seed goes to the average register and then out via the output state.
// Later samples run the update through a bit-serial multiplier, one alpha bit
// per cycle, with the smoothing factor register as alpha, or with the default
// alpha, which first runs 18 divide steps to form 131072/(N+1). One item is in
// work at a time; a finished result waits in the output register while the
// next transaction is already accepted.
// Depends on ewss_pkg, ewss_divider, ewss_multiplier and the macro header.
`include "ema_with_sma_seed_unit_macros.svh"

module ema_with_sma_seed_unit import ewss_pkg::*; #(
   parameter int MAX_PERIOD = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PRICE_W-1:0]    req_close_price,
   input  logic [TIME_W-1:0]     req_sample_time,
   input  logic                  req_series_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PRICE_W-1:0]    rsp_ema_value,
   output logic [TIME_W-1:0]     rsp_result_time,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // the period register is 11 bits, so the cap never exceeds its range
   localparam int PERIOD_CAP = (MAX_PERIOD > 2047) ? 2047 : MAX_PERIOD;
   localparam int CNT_W      = $clog2(PERIOD_CAP + 1);
   localparam int SUM_W      = PRICE_W + $clog2(PERIOD_CAP);
   localparam int DIVS_W     = $clog2(PERIOD_CAP + 2);
   localparam int ITER_W     = $clog2(SUM_W + 1);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SEED_DIV  = 3'd1;
   localparam logic [2:0] ST_ALPHA_DIV = 3'd2;
   localparam logic [2:0] ST_MUL       = 3'd3;
   localparam logic [2:0] ST_OUT       = 3'd4;

   // configuration
   logic [PERIOD_W-1:0] period_ff;
   logic                def_alpha_ff;
   logic [ALPHA_W-1:0]  smooth_ff;
   logic                csr_wr;
   logic [1:0]          csr_index;

   // series state
   logic [2:0]          state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                seeded_ff, seeded_in;
   logic [PRICE_W-1:0]  avg_ff, avg_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic                up_ff, up_in;
   logic [PRICE_W-1:0]  diff_ff, diff_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0]  rsp_ema_ff, rsp_ema_in;
   logic [TIME_W-1:0]   rsp_time_ff, rsp_time_in;

   logic                accept;
   logic [CNT_W-1:0]    n_eff;
   logic                seeded_eff;
   logic [SUM_W-1:0]    sum_new;
   logic [CNT_W-1:0]    cnt_new;
   logic                warm_done;
   logic                up_now;
   logic [PRICE_W-1:0]  diff_now;
   logic                out_free;

   logic                div_start;
   logic [SUM_W-1:0]    div_dividend;
   logic [DIVS_W-1:0]   div_divisor;
   logic [ITER_W-1:0]   div_iter;
   serial_status_type   div_stat;
   logic [SUM_W-1:0]    div_quot;

   logic                mul_start;
   logic [ALPHA_W-1:0]  mul_alpha;
   logic [PRICE_W-1:0]  mul_operand;
   serial_status_type   mul_stat;
   logic [PROD_W-1:0]   mul_prod;
   logic [PRICE_W:0]    step;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_W'(20);
         def_alpha_ff <= 1'b1;
         smooth_ff    <= ALPHA_W'(6241);
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_PERIOD:        period_ff    <= csr_pwdata[PERIOD_W-1:0];
            REG_DEFAULT_ALPHA: def_alpha_ff <= csr_pwdata[0];
            REG_SMOOTHING:     smooth_ff    <= csr_pwdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PERIOD:        csr_prdata = CSR_DATA_W'(period_ff);
         REG_DEFAULT_ALPHA: csr_prdata = CSR_DATA_W'(def_alpha_ff);
         REG_SMOOTHING:     csr_prdata = CSR_DATA_W'(smooth_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- transaction intake ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (period_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (period_ff > PERIOD_W'(PERIOD_CAP)) begin
         n_eff = CNT_W'(PERIOD_CAP);
      end else begin
         n_eff = period_ff[CNT_W-1:0];
      end
   end

   assign seeded_eff = seeded_ff && !req_series_start;
   assign sum_new    = (req_series_start ? '0 : sum_ff) + SUM_W'(req_close_price);
   assign cnt_new    = (req_series_start ? '0 : cnt_ff) + CNT_W'(1);
   assign warm_done  = (cnt_new >= n_eff);
   assign up_now     = (req_close_price >= avg_ff);
   assign diff_now   = up_now ? (req_close_price - avg_ff) : (avg_ff - req_close_price);

   // ---------------- serial units ----------------
   assign div_start    = accept && (seeded_eff ? def_alpha_ff : warm_done);
   assign div_dividend = seeded_eff ? {ALPHA_DIVD, {(SUM_W - ALPHA_DIVD_W){1'b0}}} : sum_new;
   assign div_divisor  = seeded_eff ? (DIVS_W'(n_eff) + DIVS_W'(1)) : DIVS_W'(cnt_new);
   assign div_iter     = seeded_eff ? ITER_W'(ALPHA_DIVD_W) : ITER_W'(SUM_W);

   ewss_divider #(
      .DIVD_W (SUM_W),
      .DIVS_W (DIVS_W),
      .ITER_W (ITER_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .iterations (div_iter),
      .status     (div_stat),
      .quotient   (div_quot)
   );

   assign mul_start = (accept && seeded_eff && !def_alpha_ff)
                   || (state_ff == ST_ALPHA_DIV && div_stat.done);
   assign mul_alpha = (state_ff == ST_ALPHA_DIV)
                    ? clamp_alpha(div_quot[ALPHA_DIVD_W-1:0])
                    : clamp_alpha(ALPHA_DIVD_W'(smooth_ff));
   assign mul_operand = (state_ff == ST_IDLE) ? diff_now : diff_ff;

   ewss_multiplier u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .alpha   (mul_alpha),
      .operand (mul_operand),
      .status  (mul_stat),
      .product (mul_prod)
   );

   // floor of a negative step rounds its magnitude up
   assign step = mul_prod[PROD_W-1:16]
               + (PRICE_W + 1)'(!up_ff && (mul_prod[15:0] != '0));

   // ---------------- sequencer ----------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      seeded_in    = seeded_ff;
      avg_in       = avg_ff;
      time_in      = time_ff;
      up_in        = up_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ema_in   = rsp_ema_ff;
      rsp_time_in  = rsp_time_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               time_in = req_sample_time;
               up_in   = up_now;
               diff_in = diff_now;
               if (!seeded_eff) begin
                  if (!warm_done) begin
                     sum_in    = sum_new;
                     cnt_in    = cnt_new;
                     seeded_in = 1'b0;
                  end else begin
                     sum_in    = '0;
                     cnt_in    = '0;
                     seeded_in = 1'b1;
                     state_in  = ST_SEED_DIV;
                  end
               end else begin
                  state_in = def_alpha_ff ? ST_ALPHA_DIV : ST_MUL;
               end
            end
         end
         ST_SEED_DIV: begin
            if (div_stat.done) begin
               avg_in   = (div_quot > SUM_W'(PRICE_MAX)) ? PRICE_MAX : div_quot[PRICE_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_ALPHA_DIV: begin
            if (div_stat.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               avg_in   = up_ff ? (avg_ff + step[PRICE_W-1:0]) : (avg_ff - step[PRICE_W-1:0]);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ema_in   = avg_ff;
               rsp_time_in  = time_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         seeded_ff    <= 1'b0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         seeded_ff    <= seeded_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      time_ff     <= time_in;
      up_ff       <= up_in;
      diff_ff     <= diff_in;
      rsp_ema_ff  <= rsp_ema_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ema_value   = rsp_ema_ff;
   assign rsp_result_time = rsp_time_ff;

   `EWSS_ASSERT_ALWAYS(a_cnt_capped, clock, reset, cnt_ff < CNT_W'(PERIOD_CAP))
   `EWSS_ASSERT_IMPL(a_mul_in_flight, clock, reset, state_ff == ST_MUL,
      mul_stat.busy || mul_stat.done)
   `EWSS_ASSERT_IMPL(a_div_in_flight, clock, reset,
      state_ff == ST_SEED_DIV || state_ff == ST_ALPHA_DIV,
      div_stat.busy || div_stat.done)
   `EWSS_ASSERT_NEXT(a_result_posted, clock, reset, state_ff == ST_OUT && out_free,
      rsp_valid_ff && state_ff == ST_IDLE)

endmodule
